// ----- sv/two_level_page_table_engine_macros.svh -----
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_MACROS_SVH

// same-cycle implication
`define TLPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tlpt_pkg.sv -----
package tlpt_pkg;

  localparam int unsigned NumTablesDef    = 16;
  localparam int unsigned EntriesPerTable = 1024;
  localparam int unsigned DirSlots        = 1024;
  localparam int unsigned IdxW            = 10;
  localparam int unsigned FrameShift      = 12;
  localparam int unsigned EntryW          = 32;
  localparam int unsigned FrameW          = 20;
  localparam int unsigned FlagsW          = 12;
  localparam int unsigned VpnW            = 20;

  typedef logic [1:0] op_t;
  localparam op_t OP_LOOKUP = 2'd0;
  localparam op_t OP_MAP    = 2'd1;
  localparam op_t OP_UNMAP  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK          = 2'd0;
  localparam status_t STATUS_NO_TABLE    = 2'd1;
  localparam status_t STATUS_NOT_PRESENT = 2'd2;
  localparam status_t STATUS_POOL_EMPTY  = 2'd3;

  typedef struct packed {
    op_t                operation;
    logic [VpnW-1:0]    vpn;
    logic [FrameW-1:0]  phys_frame;
    logic [FlagsW-1:0]  flags;
    logic               keep_frame;
  } req_t;

  typedef struct packed {
    logic [EntryW-1:0]  entry;
    logic [FrameW-1:0]  frame_out;
    logic               table_present;
    logic               flush_needed;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    logic init_step;
    logic capture;
    logic tbl_rd;
    logic eval;
    logic alloc_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_alloc;
    logic pool_empty;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/tlpt_stream_if.sv -----
interface tlpt_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/two_level_page_table_engine.sv -----
// Two-level page table engine.
// req_i carries one operation per item (lookup, map, unmap); rsp_o returns
// one result item per request: the entry, its frame, whether a table was
// bound, whether the translation cache needs a flush, and a status code.
// Both channels use valid/ready; an item moves when both are high.
// After reset the directory valid bits are swept clear, one slot a cycle,
// so req_i.ready stays low until every slot is clear.
// After acceptance each item passes through these steps: the directory
// is read at the accepting edge, then the table memory is read, then the
// entry is evaluated and written back, then, once it is free, the output
// register is loaded; ready returns with it.
// A map that binds a new table from the pool clears that table one entry
// per cycle through the single table write port.
// Items do not overlap: a new item is accepted only after the previous
// one has loaded the output register.
// The output register holds a result until rsp_o.ready; meanwhile the next
// item is accepted and processed, then waits for the register to free.
`include "two_level_page_table_engine_macros.svh"

module two_level_page_table_engine #(
  parameter int unsigned NUM_TABLES = tlpt_pkg::NumTablesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tlpt_stream_if.sink   req_i,
  tlpt_stream_if.source rsp_o
);
  import tlpt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp_data;

  tlpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tlpt_dp #(
    .NUM_TABLES (NUM_TABLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_data_i  (req_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_data_o  (rsp_data)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;
  assign rsp_o.data  = rsp_data;

  `TLPT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, req_i.valid && req_ready, !req_ready, "item accepted while previous one in flight")
  `TLPT_ASSERT_IMP(a_alloc_has_pool, clk_i, rst_ni, cmd.alloc_step, !sts.pool_empty, "table allocation with empty pool")
  `TLPT_ASSERT_IMP(a_load_when_free, clk_i, rst_ni, cmd.load_out, sts.out_free, "output register overwritten")

endmodule

// ----- sv/tlpt_ctrl.sv -----
module tlpt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  tlpt_pkg::sts_t sts_i,
  output tlpt_pkg::cmd_t cmd_o
);
  import tlpt_pkg::*;

  typedef enum logic [2:0] {
    StInit,
    StIdle,
    StDir,
    StEval,
    StClear,
    StResp
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StInit: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StDir;
        end
      end
      StDir: begin
        cmd_o.tbl_rd = 1'b1;
        state_d      = StEval;
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_alloc ? StClear : StResp;
      end
      StClear: begin
        cmd_o.alloc_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = StResp;
        end
      end
      StResp: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/tlpt_dp.sv -----
module tlpt_dp #(
  parameter int unsigned NUM_TABLES = tlpt_pkg::NumTablesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tlpt_pkg::req_t req_data_i,
  input  tlpt_pkg::cmd_t cmd_i,
  output tlpt_pkg::sts_t sts_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output tlpt_pkg::rsp_t rsp_data_o
);
  import tlpt_pkg::*;

  localparam int unsigned SlotW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned CntW     = $clog2(NUM_TABLES + 1);
  localparam int unsigned TblDepth = NUM_TABLES * EntriesPerTable;
  localparam int unsigned TblAw    = SlotW + IdxW;

  req_t               req_q;
  logic [IdxW-1:0]    cnt_q;
  logic [CntW-1:0]    nf_q;

  logic               dir_valid_mem [DirSlots];
  logic [SlotW-1:0]   dir_slot_mem [DirSlots];
  logic [EntryW-1:0]  tbl_mem [TblDepth];

  logic               dir_valid_rd_q;
  logic [SlotW-1:0]   dir_slot_rd_q;
  logic [EntryW-1:0]  tbl_rd_q;

  rsp_t               res_q, res_d;
  rsp_t               out_q;
  logic               out_valid_q;

  logic [IdxW-1:0]    dir_idx, tbl_idx;
  logic               have, pool_empty, need_alloc, wr_en, bind_en, sweep_last;
  logic [EntryW-1:0]  old_entry, new_entry, wr_entry;
  logic               tbl_we;
  logic [TblAw-1:0]   tbl_wa;
  logic [EntryW-1:0]  tbl_wd;

  assign dir_idx    = req_q.vpn[VpnW-1:IdxW];
  assign tbl_idx    = req_q.vpn[IdxW-1:0];
  assign have       = dir_valid_rd_q;
  assign old_entry  = tbl_rd_q;
  assign pool_empty = (nf_q >= CntW'(NUM_TABLES));
  assign sweep_last = (cnt_q == '1);
  assign bind_en    = cmd_i.alloc_step && sweep_last;
  assign new_entry  = req_q.keep_frame ? {old_entry[EntryW-1:FrameShift], req_q.flags}
                                       : {req_q.phys_frame, req_q.flags};

  always_comb begin
    res_d      = '0;
    wr_en      = 1'b0;
    wr_entry   = new_entry;
    need_alloc = 1'b0;
    case (req_q.operation)
      OP_MAP: begin
        if (have) begin
          res_d.entry         = new_entry;
          res_d.table_present = 1'b1;
          res_d.flush_needed  = (old_entry != new_entry);
          res_d.status        = STATUS_OK;
          wr_en               = 1'b1;
        end else if (req_q.keep_frame) begin
          res_d.status = STATUS_NO_TABLE;
        end else if (pool_empty) begin
          res_d.status = STATUS_POOL_EMPTY;
        end else begin
          res_d.entry  = new_entry;
          res_d.status = STATUS_OK;
          need_alloc   = 1'b1;
        end
      end
      OP_UNMAP: begin
        wr_entry = '0;
        if (!have) begin
          res_d.status = STATUS_NO_TABLE;
        end else if (!old_entry[0]) begin
          res_d.entry         = old_entry;
          res_d.table_present = 1'b1;
          res_d.status        = STATUS_NOT_PRESENT;
        end else begin
          res_d.table_present = 1'b1;
          res_d.flush_needed  = 1'b1;
          res_d.status        = STATUS_OK;
          wr_en               = 1'b1;
        end
      end
      default: begin
        if (have) begin
          res_d.entry         = old_entry;
          res_d.table_present = 1'b1;
          res_d.status        = STATUS_OK;
        end else begin
          res_d.status = STATUS_NO_TABLE;
        end
      end
    endcase
    res_d.frame_out = res_d.entry[EntryW-1:FrameShift];
  end

  assign sts_o.need_alloc = need_alloc;
  assign sts_o.pool_empty = pool_empty;
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

  // table write port: clear sweep on allocation, else single entry update
  assign tbl_we = cmd_i.alloc_step || (cmd_i.eval && wr_en);
  assign tbl_wa = cmd_i.alloc_step ? {nf_q[SlotW-1:0], cnt_q} : {dir_slot_rd_q, tbl_idx};
  assign tbl_wd = cmd_i.alloc_step ? ((cnt_q == tbl_idx) ? res_q.entry : '0) : wr_entry;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_data_i;
    end
    if (cmd_i.eval) begin
      res_q <= res_d;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step) begin
      dir_valid_mem[cnt_q] <= 1'b0;
    end else if (bind_en) begin
      dir_valid_mem[dir_idx] <= 1'b1;
    end
    if (cmd_i.capture) begin
      dir_valid_rd_q <= dir_valid_mem[req_data_i.vpn[VpnW-1:IdxW]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bind_en) begin
      dir_slot_mem[dir_idx] <= nf_q[SlotW-1:0];
    end
    if (cmd_i.capture) begin
      dir_slot_rd_q <= dir_slot_mem[req_data_i.vpn[VpnW-1:IdxW]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (cmd_i.tbl_rd) begin
      tbl_rd_q <= tbl_mem[{dir_slot_rd_q, tbl_idx}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      nf_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.init_step || cmd_i.alloc_step) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
      if (bind_en) begin
        nf_q <= nf_q + CntW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_data_o  = out_q;

endmodule
